// ----- rtl/core/rgb_sobel_gray_threshold_assert.svh -----
// ---------------------------------------------------------------------------
// rgb_sobel_gray_threshold_assert.svh
// Assertion macros shared by the rsg RTL; they expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef RGB_SOBEL_GRAY_THRESHOLD_ASSERT_SVH
`define RGB_SOBEL_GRAY_THRESHOLD_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RSG_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RSG_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rsg_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsg_pkg
// Shared types and constants of the RGB Sobel / gray / threshold filter.
// ---------------------------------------------------------------------------
package rsg_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;

  localparam int PIX_W    = 8;
  localparam int KERNEL_W = 36;
  localparam int IMG_W_W  = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = KERNEL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  localparam logic [KERNEL_W-1:0] KERNEL_RESET = 36'hFEF000121;
  localparam logic [IMG_W_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [PIX_W-1:0]    THRESH_RESET = 8'd160;

  // gray weights, 8 fractional bits
  localparam logic [15:0] GRAY_R = 16'd77;
  localparam logic [15:0] GRAY_G = 16'd151;
  localparam logic [15:0] GRAY_B = 16'd28;

  localparam logic [PIX_W-1:0] BIN_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] BIN_OFF = 8'h00;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  // which window rows / columns lie inside the image
  typedef struct packed {
    logic up2;
    logic up1;
    logic left2;
    logic left1;
  } win_mask_t;

  typedef struct packed {
    rgb_t      pix;
    win_mask_t mask;
  } job_t;

  typedef struct packed {
    logic [KERNEL_W-1:0] kernel;
    logic [IMG_W_W-1:0]  image_width;
    logic [PIX_W-1:0]    threshold;
  } cfg_t;

endpackage

// ----- rtl/core/rsg_ifs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsg_ifs
// Valid/ready channel interfaces: pixel in, filter result out, config write.
// ---------------------------------------------------------------------------
interface rsg_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsg_pkg::PIX_W-1:0] red;
  logic [rsg_pkg::PIX_W-1:0] green;
  logic [rsg_pkg::PIX_W-1:0] blue;
  logic                      frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface rsg_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [rsg_pkg::PIX_W-1:0] gray_level;
  logic [rsg_pkg::PIX_W-1:0] binary_pixel;

  modport source (output valid, gray_level, binary_pixel, input ready);
  modport sink   (input valid, gray_level, binary_pixel, output ready);
endinterface

interface rsg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rsg_pkg::CFG_IDX_W-1:0]  index;
  logic [rsg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/rgb_sobel_gray_threshold.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_sobel_gray_threshold
// 3x3 edge filter on an RGB raster stream with gray conversion and threshold.
// ---------------------------------------------------------------------------
// Each accepted pixel gives exactly one result. The front end takes a pixel
// in any cycle the 2-entry queue has room; the back end handles one pixel at
// a time in three steps (line-store read, window sum, gray conversion into the
// output register) and takes the next pixel from the queue only after the
// last step; a stalled result holds the back end in its last step. When the
// queue and back end are idle, out_pix.valid rises once an accepted pixel has
// passed through the queue and those steps. The line stores hold MAX_WIDTH
// pixels each, need no clearing after reset, and image_width is clipped to
// 1..MAX_WIDTH. Configuration is accepted in every cycle and must only be
// written while no pixel is in flight.
// ---------------------------------------------------------------------------
module rgb_sobel_gray_threshold #(
  parameter int MAX_WIDTH = rsg_pkg::MAX_WIDTH_DEF
) (
  input logic            clk,
  input logic            rst_n,
  rsg_pix_in_if.sink     in_pix,
  rsg_pix_out_if.source  out_pix,
  rsg_cfg_if.sink        cfg_wr
);

  localparam int AW = $clog2(MAX_WIDTH);

  rsg_pkg::cfg_t cfg_r;

  logic          push, q_full, pop, q_valid;
  rsg_pkg::job_t push_job, q_job;
  logic [AW-1:0] push_col, q_col;
  rsg_pkg::rgb_t in_rgb;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kernel      <= rsg_pkg::KERNEL_RESET;
      cfg_r.image_width <= rsg_pkg::WIDTH_RESET;
      cfg_r.threshold   <= rsg_pkg::THRESH_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        rsg_pkg::CFG_KERNEL: cfg_r.kernel      <= cfg_wr.data;
        rsg_pkg::CFG_WIDTH:  cfg_r.image_width <= cfg_wr.data[rsg_pkg::IMG_W_W-1:0];
        rsg_pkg::CFG_THRESH: cfg_r.threshold   <= cfg_wr.data[rsg_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_rgb.red   = in_pix.red;
  assign in_rgb.green = in_pix.green;
  assign in_rgb.blue  = in_pix.blue;

  rsg_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_pix.valid),
    .in_ready       (in_pix.ready),
    .in_pix         (in_rgb),
    .in_frame_start (in_pix.frame_start),
    .image_width    (cfg_r.image_width),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job),
    .push_col       (push_col)
  );

  rsg_fifo #(
    .AW (AW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_col   (push_col),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_job   (q_job),
    .head_col   (q_col)
  );

  rsg_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_col      (q_col),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_valid  (out_pix.valid),
    .out_ready  (out_pix.ready),
    .out_gray   (out_pix.gray_level),
    .out_binary (out_pix.binary_pixel)
  );

endmodule

// ----- rtl/core/rsg_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsg_front
// Accepts pixels, tracks column/row position and tags each transaction with
// its line-store address and window edge mask.
// ---------------------------------------------------------------------------
module rsg_front #(
  parameter int MAX_WIDTH = rsg_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rsg_pkg::rgb_t                 in_pix,
  input  logic                          in_frame_start,
  input  logic [rsg_pkg::IMG_W_W-1:0]   image_width,
  input  logic                          q_full,
  output logic                          push,
  output rsg_pkg::job_t                 push_job,
  output logic [$clog2(MAX_WIDTH)-1:0]  push_col
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (AW + 1 > rsg_pkg::IMG_W_W) ? AW + 1 : rsg_pkg::IMG_W_W;

  logic [AW-1:0]   col_r, col_nxt, col_cur;
  logic [1:0]      row_r, row_nxt, row_cur;
  logic [CMPW-1:0] width_x, w_eff, col_inc;
  logic            last_col;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? 2'd0 : row_r;

  always_comb begin
    width_x = CMPW'(image_width);
    if (width_x == '0) begin
      w_eff = CMPW'(1);
    end else if (width_x > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = width_x;
    end
    col_inc  = CMPW'(col_cur) + CMPW'(1);
    last_col = (col_inc >= w_eff);
  end

  always_comb begin
    push_job.pix        = in_pix;
    push_job.mask.up2   = (row_cur == 2'd2);
    push_job.mask.up1   = (row_cur != 2'd0);
    push_job.mask.left2 = (col_cur[AW-1:1] != '0);
    push_job.mask.left1 = (col_cur != '0);
    push_col            = col_cur;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      col_nxt = last_col ? '0 : col_inc[AW-1:0];
      row_nxt = (last_col && row_cur != 2'd2) ? row_cur + 2'd1 : row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 2'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- rtl/core/rsg_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsg_fifo
// Short queue of tagged pixel transactions between front and back end.
// ---------------------------------------------------------------------------
module rsg_fifo #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsg_pkg::job_t push_job,
  input  logic [AW-1:0] push_col,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rsg_pkg::job_t head_job,
  output logic [AW-1:0] head_col
);

  localparam int DEPTH = rsg_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  rsg_pkg::job_t job_mem [DEPTH];
  logic [AW-1:0] col_mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = job_mem[rd_ptr_r];
  assign head_col   = col_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_mem[wr_ptr_r] <= push_job;
      col_mem[wr_ptr_r] <= push_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/rsg_back.sv -----
`timescale 1ns / 1ps
`include "rgb_sobel_gray_threshold_assert.svh"
// ---------------------------------------------------------------------------
// rsg_back
// Line stores, 3x3 window, kernel sums, clamp, gray conversion, threshold
// and the output register.
// ---------------------------------------------------------------------------
module rsg_back #(
  parameter int MAX_WIDTH = rsg_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rsg_pkg::job_t                 q_job,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  output logic                          pop,
  input  rsg_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsg_pkg::PIX_W-1:0]     out_gray,
  output logic [rsg_pkg::PIX_W-1:0]     out_binary
);

  localparam int AW = $clog2(MAX_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_GRAY = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic       load_out;

  rsg_pkg::rgb_t prev_mem  [MAX_WIDTH];
  rsg_pkg::rgb_t prev2_mem [MAX_WIDTH];
  rsg_pkg::rgb_t prev_q, prev2_q;

  rsg_pkg::job_t job_r;
  logic [AW-1:0] col_r;
  rsg_pkg::rgb_t win_r [6];

  logic signed [15:0] sum_r [3];
  logic signed [15:0] acc   [3];

  rsg_pkg::rgb_t      grid   [3][3];
  logic [2:0]         row_ok, col_ok;
  logic [3:0]         coef_n;
  logic signed [15:0] coef_x;

  logic [7:0]  clamp_c [3];
  logic [15:0] gray_sum;
  logic [7:0]  gray;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] gray_r, bin_r;

  function automatic logic [7:0] clamp8(input logic signed [15:0] s);
    logic [7:0] c;
    if (s[15]) begin
      c = 8'd0;
    end else if (s > 16'sd255) begin
      c = 8'd255;
    end else begin
      c = s[7:0];
    end
    return c;
  endfunction

  // control
  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop    = 1'b1;
          st_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        st_nxt = ST_GRAY;
      end
      ST_GRAY: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // line stores: read at pop, written back during the sum cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      prev_q  <= prev_mem[q_col];
      prev2_q <= prev2_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_SUM) begin
      prev_mem[col_r]  <= job_r.pix;
      prev2_mem[col_r] <= prev_q;
    end
  end

  // window sums, rows r-2..r by columns c-2..c
  always_comb begin
    grid[0][0] = win_r[1];
    grid[0][1] = win_r[0];
    grid[0][2] = prev2_q;
    grid[1][0] = win_r[3];
    grid[1][1] = win_r[2];
    grid[1][2] = prev_q;
    grid[2][0] = win_r[5];
    grid[2][1] = win_r[4];
    grid[2][2] = job_r.pix;
    row_ok = {1'b1, job_r.mask.up1, job_r.mask.up2};
    col_ok = {1'b1, job_r.mask.left1, job_r.mask.left2};
    coef_n = 4'd0;
    coef_x = 16'sd0;
    for (int l = 0; l < 3; l++) begin
      acc[l] = 16'sd0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef_n = cfg.kernel[4*(i+3*j) +: 4];
        coef_x = {{12{coef_n[3]}}, coef_n};
        if (row_ok[i] && col_ok[j]) begin
          acc[0] = acc[0] + coef_x * $signed({8'd0, grid[i][j].red});
          acc[1] = acc[1] + coef_x * $signed({8'd0, grid[i][j].green});
          acc[2] = acc[2] + coef_x * $signed({8'd0, grid[i][j].blue});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
      col_r <= q_col;
    end
    if (st_r == ST_SUM) begin
      for (int l = 0; l < 3; l++) begin
        sum_r[l] <= acc[l];
      end
      win_r[1] <= win_r[0];
      win_r[0] <= prev2_q;
      win_r[3] <= win_r[2];
      win_r[2] <= prev_q;
      win_r[5] <= win_r[4];
      win_r[4] <= job_r.pix;
    end
  end

  // clamp, gray, threshold
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      clamp_c[l] = clamp8(sum_r[l]);
    end
    gray_sum = rsg_pkg::GRAY_R * {8'd0, clamp_c[0]}
             + rsg_pkg::GRAY_G * {8'd0, clamp_c[1]}
             + rsg_pkg::GRAY_B * {8'd0, clamp_c[2]};
    gray = gray_sum[15:8];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      gray_r <= gray;
      bin_r  <= (gray > cfg.threshold) ? rsg_pkg::BIN_ON : rsg_pkg::BIN_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_gray   = gray_r;
  assign out_binary = bin_r;

  `RSG_CHECK_NEXT(a_pop_then_sum, pop, st_r == ST_SUM, "pop not followed by sum cycle")
  `RSG_CHECK_NOW(a_sum_after_pop, st_r == ST_SUM, $past(pop), "sum cycle without line read")
  `RSG_CHECK_NOW(a_out_from_gray, $rose(out_valid_r), $past(st_r) == ST_GRAY, "result not from gray")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for rgb_sobel_gray_threshold: drives random and directed
// pixel streams under random source gaps and sink stalls, predicts each
// filtered gray level and binary pixel, and checks every result transaction
// in order against the prediction.
// ---------------------------------------------------------------------------
module testbench;
  import rsg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] bin;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  rsg_pix_in_if  pix_in ();
  rsg_pix_out_if pix_out ();
  rsg_cfg_if     cfg_if ();

  rgb_sobel_gray_threshold u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_in),
    .out_pix (pix_out),
    .cfg_wr  (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [KERNEL_W-1:0] kern_reg;
  logic [IMG_W_W-1:0]  width_reg;
  logic [PIX_W-1:0]    thresh_reg;
  rgb_t                row_above  [MAX_WIDTH_DEF];
  rgb_t                row_above2 [MAX_WIDTH_DEF];
  rgb_t                win_c1 [3];
  rgb_t                win_c2 [3];
  int                  next_col;
  int                  rows_done;

  result_t pending_results[$];
  int      errors = 0;
  int      cycle_count = 0;
  bit      steady_phase = 1'b0;

  task automatic filter_pixel(input rgb_t px, input logic fs);
    rgb_t    grid [3][3];
    int      sum [3];
    int      clamp_v [3];
    int      col, w, coef, gray;
    result_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    if (fs) begin
      next_col = 0;
      rows_done = 0;
    end
    col = (next_col >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : next_col;
    grid[0][2] = row_above2[col];
    grid[1][2] = row_above[col];
    grid[2][2] = px;
    for (int i = 0; i < 3; i++) begin
      grid[i][0] = win_c2[i];
      grid[i][1] = win_c1[i];
    end
    sum = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!((i == 0 && rows_done < 2) || (i == 1 && rows_done < 1) ||
              (j == 0 && col < 2) || (j == 1 && col < 1))) begin
          coef = $signed(kern_reg[4*(i+3*j) +: 4]);
          sum[0] += coef * int'(grid[i][j].red);
          sum[1] += coef * int'(grid[i][j].green);
          sum[2] += coef * int'(grid[i][j].blue);
        end
      end
    end
    for (int l = 0; l < 3; l++)
      clamp_v[l] = (sum[l] < 0) ? 0 : ((sum[l] > 255) ? 255 : sum[l]);
    gray = (int'(GRAY_R) * clamp_v[0] + int'(GRAY_G) * clamp_v[1] +
            int'(GRAY_B) * clamp_v[2]) >> 8;
    res.gray = 8'(gray);
    res.bin  = (gray > int'(thresh_reg)) ? BIN_ON : BIN_OFF;
    pending_results.push_back(res);

    row_above2[col] = grid[1][2];
    row_above[col]  = px;
    for (int i = 0; i < 3; i++) begin
      win_c2[i] = win_c1[i];
      win_c1[i] = grid[i][2];
    end
    if (col + 1 >= w) begin
      next_col = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      next_col = col + 1;
    end
  endtask

  // accepted pixel transactions feed the predictor
  always @(posedge clk) begin
    if (rst_n && pix_in.valid && pix_in.ready)
      filter_pixel({pix_in.blue, pix_in.green, pix_in.red}, pix_in.frame_start);
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && pix_out.valid && pix_out.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: gray_level=%0d binary_pixel=%0d", $time,
                 pix_out.gray_level, pix_out.binary_pixel);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (pix_out.gray_level !== want.gray) begin
          $display("%0t: gray_level mismatch: expected %0d, actual %0d", $time,
                   want.gray, pix_out.gray_level);
          errors++;
        end
        if (pix_out.binary_pixel !== want.bin) begin
          $display("%0t: binary_pixel mismatch: expected %0d, actual %0d", $time,
                   want.bin, pix_out.binary_pixel);
          errors++;
        end
      end
    end
  end

  // sink stalls
  always @(negedge clk) begin
    pix_out.ready = steady_phase ? 1'b1 : ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rgb_sobel_gray_threshold");
      $finish;
    end
  end

  task automatic send_pixel(input rgb_t px, input logic fs);
    while (!steady_phase && $urandom_range(99) < 8) begin
      pix_in.valid = 1'b0;
      @(negedge clk);
    end
    pix_in.valid       = 1'b1;
    pix_in.red         = px.red;
    pix_in.green       = px.green;
    pix_in.blue        = px.blue;
    pix_in.frame_start = fs;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pix_in.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_KERNEL: kern_reg   = val[KERNEL_W-1:0];
      CFG_WIDTH:  width_reg  = val[IMG_W_W-1:0];
      CFG_THRESH: thresh_reg = val[PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // first pixel opens a frame; noise_pct adds stray frame starts
  task automatic send_random_pixels(input int count, input int noise_pct,
                                    input int pause_at);
    logic [31:0] r32;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) wait_drained();
      r32 = $urandom();
      send_pixel(r32[23:0], (n == 0) || ($urandom_range(99) < noise_pct));
    end
  endtask

  task automatic test_reset_settings();
    send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b1);
    send_pixel({8'h00, 8'h00, 8'h00}, 1'b0);
    send_pixel({8'hFF, 8'h00, 8'hFF}, 1'b0);
    send_pixel({8'h00, 8'hFF, 8'h00}, 1'b0);
    wait_drained();
  endtask

  // zero width acts as one pixel per line
  task automatic test_unit_width();
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_KERNEL, 36'h777777777);
    write_reg(CFG_THRESH, 36'd0);
    send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b1);
    send_pixel({8'h00, 8'h00, 8'h00}, 1'b0);
    send_pixel({8'h01, 8'h02, 8'h03}, 1'b0);
    send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b0);
    wait_drained();
  endtask

  task automatic test_width_saturation();
    write_reg(CFG_WIDTH, 36'd2047);
    write_reg(CFG_KERNEL, 36'(KERNEL_RESET));
    write_reg(CFG_THRESH, 36'd255);
    send_random_pixels(3, 0, -1);
    wait_drained();
  endtask

  task automatic test_narrow_image();
    write_reg(CFG_WIDTH, 36'd3);
    write_reg(CFG_KERNEL, 36'h787878787);
    write_reg(CFG_THRESH, 36'd128);
    send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b1);
    send_pixel({8'h00, 8'h00, 8'h00}, 1'b0);
    send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b0);
    send_pixel({8'h00, 8'hFF, 8'h00}, 1'b0);
    send_pixel({8'hFF, 8'h00, 8'hFF}, 1'b0);
    send_pixel({8'h80, 8'h7F, 8'h01}, 1'b0);
    wait_drained();
  endtask

  // width drops below the current column: line ends after that pixel
  task automatic test_width_lowered_midline();
    write_reg(CFG_WIDTH, 36'd4);
    write_reg(CFG_KERNEL, 36'(KERNEL_RESET));
    write_reg(CFG_THRESH, 36'd60);
    send_random_pixels(6, 0, -1);
    wait_drained();
    write_reg(CFG_WIDTH, 36'd2);
    for (int n = 0; n < 3; n++) send_pixel(rgb_t'($urandom_range(24'hFFFFFF)), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_frames();
    logic [63:0]       r64;
    logic [KERNEL_W-1:0] kern;
    int                width;
    int                thresh;
    for (int phase = 0; phase < 12; phase++) begin
      r64 = {$urandom(), $urandom()};
      case ($urandom_range(7))
        0: kern = 36'h777777777;
        1: kern = 36'h888888888;
        2: kern = '0;
        3: kern = KERNEL_RESET;
        default: kern = r64[KERNEL_W-1:0];
      endcase
      case ($urandom_range(9))
        0: width = 1;
        1: width = (phase < 6) ? $urandom_range(1025, 2047) : 1024;
        2, 3, 4, 5: width = $urandom_range(2, 6);
        6, 7, 8: width = $urandom_range(7, 16);
        default: width = $urandom_range(17, 40);
      endcase
      case ($urandom_range(5))
        0: thresh = 0;
        1: thresh = 255;
        default: thresh = $urandom_range(255);
      endcase
      write_reg(CFG_KERNEL, 36'(kern));
      write_reg(CFG_WIDTH, 36'(width));
      write_reg(CFG_THRESH, 36'(thresh));
      steady_phase = (phase == 4);
      send_random_pixels(46, 3, (phase == 6) ? 23 : -1);
      wait_drained();
      steady_phase = 1'b0;
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    pix_in.valid       = 1'b0;
    pix_in.red         = '0;
    pix_in.green       = '0;
    pix_in.blue        = '0;
    pix_in.frame_start = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_KERNEL;
    cfg_if.data        = '0;
    kern_reg   = KERNEL_RESET;
    width_reg  = WIDTH_RESET;
    thresh_reg = THRESH_RESET;
    for (int k = 0; k < MAX_WIDTH_DEF; k++) begin
      row_above[k]  = '0;
      row_above2[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      win_c1[i] = '0;
      win_c2[i] = '0;
    end
    next_col  = 0;
    rows_done = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_settings();
    test_unit_width();
    test_width_saturation();
    test_narrow_image();
    test_width_lowered_midline();
    test_random_frames();

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS rgb_sobel_gray_threshold");
    end else begin
      $display("FAIL rgb_sobel_gray_threshold");
    end
    $finish;
  end

endmodule
